// ===== rtl/owm_pkg.sv =====
// Shared types, constants and helpers for the one-wire bus master timing block.
`timescale 1ns / 1ps

package owm_pkg;

  localparam int unsigned TICK_W   = 10;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned ADDR_W   = 5;

  localparam logic [TICK_W-1:0] RESET_TAIL_TICKS = 10'd410;
  localparam logic [TICK_W-1:0] READ_TAIL_TICKS  = 10'd55;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_REL   = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_TAIL  = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW    = 3'd0,
    REG_RESET_WAIT   = 3'd1,
    REG_ONE_LOW      = 3'd2,
    REG_ONE_RELEASE  = 3'd3,
    REG_ZERO_LOW     = 3'd4,
    REG_ZERO_RELEASE = 3'd5,
    REG_READ_LOW     = 3'd6,
    REG_READ_WAIT    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [TICK_W-1:0] reset_low_ticks;
    logic [TICK_W-1:0] reset_wait_ticks;
    logic [TICK_W-1:0] one_low_ticks;
    logic [TICK_W-1:0] one_release_ticks;
    logic [TICK_W-1:0] zero_low_ticks;
    logic [TICK_W-1:0] zero_release_ticks;
    logic [TICK_W-1:0] read_low_ticks;
    logic [TICK_W-1:0] read_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic       rejected;
    logic [7:0] read_data;
    logic       presence;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } res_t;

  // Length in ticks of the current phase; zero for idle.
  function automatic logic [TICK_W-1:0] phase_len(phase_t ph, logic one, cfg_t cfg);
    logic [TICK_W-1:0] len;
    len = '0;
    case (ph)
      PH_RST_LOW:  len = cfg.reset_low_ticks;
      PH_RST_WAIT: len = cfg.reset_wait_ticks;
      PH_RST_TAIL: len = RESET_TAIL_TICKS;
      PH_WR_LOW:   len = one ? cfg.one_low_ticks : cfg.zero_low_ticks;
      PH_WR_REL:   len = one ? cfg.one_release_ticks : cfg.zero_release_ticks;
      PH_RD_LOW:   len = cfg.read_low_ticks;
      PH_RD_WAIT:  len = cfg.read_wait_ticks;
      PH_RD_TAIL:  len = READ_TAIL_TICKS;
      default:     len = '0;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/owm_regs.sv =====
// Configuration register file with APB-style access.
`timescale 1ns / 1ps

module owm_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [owm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output owm_pkg::cfg_t              cfg
);

  owm_pkg::reg_idx_t idx;
  logic              wr_en;
  logic [owm_pkg::TICK_W-1:0] rd_val;

  assign pready = 1'b1;
  assign idx    = owm_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks    <= 10'd480;
      cfg.reset_wait_ticks   <= 10'd70;
      cfg.one_low_ticks      <= 10'd6;
      cfg.one_release_ticks  <= 10'd64;
      cfg.zero_low_ticks     <= 10'd60;
      cfg.zero_release_ticks <= 10'd10;
      cfg.read_low_ticks     <= 10'd6;
      cfg.read_wait_ticks    <= 10'd9;
    end else if (wr_en) begin
      case (idx)
        owm_pkg::REG_RESET_LOW:    cfg.reset_low_ticks    <= pwdata[9:0];
        owm_pkg::REG_RESET_WAIT:   cfg.reset_wait_ticks   <= pwdata[9:0];
        owm_pkg::REG_ONE_LOW:      cfg.one_low_ticks      <= pwdata[9:0];
        owm_pkg::REG_ONE_RELEASE:  cfg.one_release_ticks  <= pwdata[9:0];
        owm_pkg::REG_ZERO_LOW:     cfg.zero_low_ticks     <= pwdata[9:0];
        owm_pkg::REG_ZERO_RELEASE: cfg.zero_release_ticks <= pwdata[9:0];
        owm_pkg::REG_READ_LOW:     cfg.read_low_ticks     <= pwdata[9:0];
        owm_pkg::REG_READ_WAIT:    cfg.read_wait_ticks    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      owm_pkg::REG_RESET_LOW:    rd_val = cfg.reset_low_ticks;
      owm_pkg::REG_RESET_WAIT:   rd_val = cfg.reset_wait_ticks;
      owm_pkg::REG_ONE_LOW:      rd_val = cfg.one_low_ticks;
      owm_pkg::REG_ONE_RELEASE:  rd_val = cfg.one_release_ticks;
      owm_pkg::REG_ZERO_LOW:     rd_val = cfg.zero_low_ticks;
      owm_pkg::REG_ZERO_RELEASE: rd_val = cfg.zero_release_ticks;
      owm_pkg::REG_READ_LOW:     rd_val = cfg.read_low_ticks;
      owm_pkg::REG_READ_WAIT:    rd_val = cfg.read_wait_ticks;
      default:                   rd_val = '0;
    endcase
  end

  assign prdata = {22'd0, rd_val};

endmodule

// ===== rtl/owm_core.sv =====
// Bus sequencer: phase state, tick counting, bit shifting and result logic.
`timescale 1ns / 1ps

module owm_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  owm_pkg::kind_t  kind,
  input  logic [7:0]      data_byte,
  input  logic            line_level,
  input  owm_pkg::cfg_t   cfg,
  output owm_pkg::res_t   res
);

  owm_pkg::phase_t            phase, phase_next;
  logic [owm_pkg::TICK_W-1:0] tick_count, tick_count_next;
  logic [2:0]                 bit_index, bit_index_next;
  logic [7:0]                 shift_byte, shift_byte_next;
  logic                       presence_flag, presence_flag_next;
  logic [7:0]                 read_byte_reg, read_byte_reg_next;
  logic [owm_pkg::TICK_W-1:0] tick_inc;
  logic [owm_pkg::TICK_W-1:0] len;
  logic                       done, rejected;

  assign tick_inc = tick_count + 10'd1;
  assign len      = owm_pkg::phase_len(phase, shift_byte[0], cfg);

  // Next state
  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_flag_next = presence_flag;
    read_byte_reg_next = read_byte_reg;
    done               = 1'b0;
    rejected           = 1'b0;
    if (kind == owm_pkg::KIND_TICK) begin
      if (phase != owm_pkg::PH_IDLE) begin
        if (tick_inc >= len) begin
          tick_count_next = '0;
          case (phase)
            owm_pkg::PH_RST_LOW: phase_next = owm_pkg::PH_RST_WAIT;
            owm_pkg::PH_RST_WAIT: begin
              presence_flag_next = ~line_level;
              phase_next         = owm_pkg::PH_RST_TAIL;
            end
            owm_pkg::PH_WR_LOW: phase_next = owm_pkg::PH_WR_REL;
            owm_pkg::PH_WR_REL: begin
              if (bit_index == 3'd7) begin
                bit_index_next = '0;
                phase_next     = owm_pkg::PH_IDLE;
                done           = 1'b1;
              end else begin
                bit_index_next  = bit_index + 3'd1;
                shift_byte_next = {1'b0, shift_byte[7:1]};
                phase_next      = owm_pkg::PH_WR_LOW;
              end
            end
            owm_pkg::PH_RD_LOW: phase_next = owm_pkg::PH_RD_WAIT;
            owm_pkg::PH_RD_WAIT: begin
              shift_byte_next[bit_index] = shift_byte[bit_index] | line_level;
              phase_next                 = owm_pkg::PH_RD_TAIL;
            end
            owm_pkg::PH_RD_TAIL: begin
              if (bit_index == 3'd7) begin
                read_byte_reg_next = shift_byte;
                bit_index_next     = '0;
                phase_next         = owm_pkg::PH_IDLE;
                done               = 1'b1;
              end else begin
                bit_index_next = bit_index + 3'd1;
                phase_next     = owm_pkg::PH_RD_LOW;
              end
            end
            default: begin
              // reset tail ends the command
              phase_next = owm_pkg::PH_IDLE;
              done       = 1'b1;
            end
          endcase
        end else begin
          tick_count_next = tick_inc;
        end
      end
    end else if (phase != owm_pkg::PH_IDLE) begin
      rejected = 1'b1;
    end else begin
      tick_count_next = '0;
      bit_index_next  = '0;
      case (kind)
        owm_pkg::KIND_RESET: phase_next = owm_pkg::PH_RST_LOW;
        owm_pkg::KIND_WRITE: begin
          shift_byte_next = data_byte;
          phase_next      = owm_pkg::PH_WR_LOW;
        end
        default: begin
          shift_byte_next = '0;
          phase_next      = owm_pkg::PH_RD_LOW;
        end
      endcase
    end
  end

  // Result word
  always_comb begin
    res.drive_low = (phase_next == owm_pkg::PH_RST_LOW) ||
                    (phase_next == owm_pkg::PH_WR_LOW)  ||
                    (phase_next == owm_pkg::PH_RD_LOW);
    res.busy_res  = (phase_next != owm_pkg::PH_IDLE);
    res.done_res  = done;
    res.presence  = presence_flag_next;
    res.read_data = read_byte_reg_next;
    res.rejected  = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= owm_pkg::PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
      read_byte_reg <= '0;
    end else if (en) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_flag <= presence_flag_next;
      read_byte_reg <= read_byte_reg_next;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == owm_pkg::PH_IDLE |-> tick_count == '0 && bit_index == '0)
    else $error("idle with nonzero counters");

  a_cmd_starts: assert property (@(posedge clk) disable iff (rst)
    en && kind != owm_pkg::KIND_TICK && phase == owm_pkg::PH_IDLE
    |=> phase != owm_pkg::PH_IDLE)
    else $error("accepted command did not start a sequence");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    !(en && done) |=> $stable(read_byte_reg))
    else $error("read byte changed without a finished command");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    en && rejected |=> $stable(phase) && $stable(shift_byte))
    else $error("rejected command disturbed the sequence");

endmodule

// ===== rtl/one_wire_master_timing.sv =====
// Top level: input word register, sequencer, output word register and config port.
//
//   channel   handshake               payload
//   s_*       s_tvalid / s_tready     s_tdata: data_byte, line_level; s_tuser: kind
//   m_*       m_tvalid / m_tready     m_tdata: result fields
//   apb       psel, penable, pwrite   paddr, pwdata, prdata, pready
//
// One word in, one word out; a word can be accepted every cycle unless m_tready stalls the output.
// Each word passes through the input register, then the sequencer logic into the output register.
// Bus timing comes from counting tick words, not from clock cycles.
// rst (synchronous) clears the sequence, pipeline valids and restores the timing registers.
// A stall on m_tready holds the output word and backs up through the input register.
`timescale 1ns / 1ps

module one_wire_master_timing (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,  // [7:0] data_byte, [8] line_level, rest zero
  input  logic [1:0]                 s_tuser,  // [1:0] kind
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,  // [0] drive_low, [1] busy_res, [2] done_res,
                                               // [3] presence, [11:4] read_data,
                                               // [12] rejected, rest zero
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [owm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  owm_pkg::cfg_t  cfg;
  owm_pkg::res_t  res, out_res;
  logic           in_valid;
  logic [7:0]     in_data;
  logic           in_line;
  logic [1:0]     in_kind;
  logic           out_load;

  assign out_load = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata[7:0];
      in_line <= s_tdata[8];
      in_kind <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'd0, out_res};

  owm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owm_core u_core (
    .clk        (clk),
    .rst        (rst),
    .en         (out_load),
    .kind       (owm_pkg::kind_t'(in_kind)),
    .data_byte  (in_data),
    .line_level (in_line),
    .cfg        (cfg),
    .res        (res)
  );

endmodule
